// ===== rtl/core/lsr_pkg.sv =====
// shared types, limiter codes and saturation helpers for the slope-limited reconstruction
// no dependencies
package lsr_pkg;

   localparam int NUM_COMP = 4;

   localparam logic [1:0] MODE_MINMOD   = 2'd0;
   localparam logic [1:0] MODE_SUPERBEE = 2'd1;
   localparam logic [1:0] MODE_VANLEER  = 2'd2;

   typedef logic [NUM_COMP-1:0][31:0] cell_type;

   // one classified request for the back end: neighbors and saturated differences
   typedef struct packed {
      cell_type prev;
      cell_type cur;
      cell_type dm;
      cell_type dp;
   } job_type;

   function automatic logic [31:0] sat33(input logic signed [32:0] v);
      logic [31:0] r;
      if (v > 33'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -33'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat34(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -34'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/lsr_front.sv =====
// front end: accepts cells, keeps the two previous cells of the line, forms differences
// depends on lsr_pkg
module lsr_front
   import lsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_density,
   input  logic [31:0] req_velocity_a,
   input  logic [31:0] req_velocity_b,
   input  logic [31:0] req_pressure,
   input  logic        req_line_start,
   input  logic        q_full,
   output logic        push,
   output job_type     push_job
);

   cell_type   m1_ff, m2_ff, cur;
   logic [1:0] seen_ff;
   logic       accept;

   assign cur[0] = req_density;
   assign cur[1] = req_velocity_a;
   assign cur[2] = req_velocity_b;
   assign cur[3] = req_pressure;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign push      = accept & ~req_line_start & (seen_ff == 2'd2);

   always_comb begin
      push_job.prev = m1_ff;
      push_job.cur  = cur;
      for (int k = 0; k < NUM_COMP; k++) begin
         push_job.dm[k] = sat33($signed({m1_ff[k][31], m1_ff[k]}) -
                                $signed({m2_ff[k][31], m2_ff[k]}));
         push_job.dp[k] = sat33($signed({cur[k][31], cur[k]}) -
                                $signed({m1_ff[k][31], m1_ff[k]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff   <= '0;
         m2_ff   <= '0;
         seen_ff <= 2'd0;
      end else if (accept) begin
         m1_ff <= cur;
         if (req_line_start) begin
            m2_ff   <= '0;
            seen_ff <= 2'd1;
         end else begin
            m2_ff <= m1_ff;
            if (seen_ff != 2'd2) begin
               seen_ff <= seen_ff + 2'd1;
            end
         end
      end
   end

endmodule

// ===== rtl/core/lsr_queue.sv =====
// two-entry queue between the front and back ends
// depends on lsr_pkg
module lsr_queue
   import lsr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    q_valid,
   output job_type q_job,
   input  logic    pop
);

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_job   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

// ===== rtl/core/lsr_back.sv =====
// back end: limits slopes one component at a time, van leer through a bit-serial divider
// depends on lsr_pkg
module lsr_back
   import lsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  mode,
   input  logic        q_valid,
   input  job_type     q_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_left_density,
   output logic [31:0] rsp_left_velocity_a,
   output logic [31:0] rsp_left_velocity_b,
   output logic [31:0] rsp_left_pressure,
   output logic [31:0] rsp_right_density,
   output logic [31:0] rsp_right_velocity_a,
   output logic [31:0] rsp_right_velocity_b,
   output logic [31:0] rsp_right_pressure
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_MAG   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_APPLY = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type   state_ff;
   logic [1:0]  k_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] a_ff, b_ff, mag_ff;
   logic        neg_ff, zero_ff;
   logic [63:0] num_ff;
   logic [32:0] den_ff, rem_ff;
   cell_type    lres_ff, rres_ff, lout_ff, rout_ff;
   logic        rsp_valid_ff;

   logic [31:0] dm, dp, mag_simple;
   logic [32:0] a2, b2, min_ab, sb1, sb2;
   logic [63:0] prod;
   logic [33:0] rem_sh;
   logic        ge, out_free;
   logic signed [32:0] h;

   assign dm = q_job.dm[k_ff];
   assign dp = q_job.dp[k_ff];

   always_comb begin
      a2     = {a_ff, 1'b0};
      b2     = {b_ff, 1'b0};
      min_ab = (a_ff < b_ff) ? {1'b0, a_ff} : {1'b0, b_ff};
      sb1    = (a2 < {1'b0, b_ff}) ? a2 : {1'b0, b_ff};
      sb2    = ({1'b0, a_ff} < b2) ? {1'b0, a_ff} : b2;
      case (mode)
         MODE_MINMOD:   mag_simple = min_ab[31:0];
         MODE_SUPERBEE: mag_simple = (sb1 > sb2) ? sb1[31:0] : sb2[31:0];
         default:       mag_simple = 32'd0;
      endcase
      prod   = {32'd0, a_ff} * {32'd0, b_ff};
      rem_sh = {rem_ff, num_ff[63]};
      ge     = (rem_sh >= {1'b0, den_ff});
      // half slope truncated toward zero, sign shared by both differences
      h = neg_ff ? -$signed({2'b00, mag_ff[31:1]}) : $signed({2'b00, mag_ff[31:1]});
   end

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign pop       = (state_ff == ST_OUT) & out_free;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_left_density     = lout_ff[0];
   assign rsp_left_velocity_a  = lout_ff[1];
   assign rsp_left_velocity_b  = lout_ff[2];
   assign rsp_left_pressure    = lout_ff[3];
   assign rsp_right_density    = rout_ff[0];
   assign rsp_right_velocity_a = rout_ff[1];
   assign rsp_right_velocity_b = rout_ff[2];
   assign rsp_right_pressure   = rout_ff[3];

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            zero_ff <= (dm == 32'd0) | (dp == 32'd0) | (dm[31] != dp[31]);
            neg_ff  <= dm[31];
            a_ff    <= dm[31] ? (~dm + 32'd1) : dm;
            b_ff    <= dm[31] ? (~dp + 32'd1) : dp;
         end
         ST_MAG: begin
            if (mode == MODE_VANLEER && !zero_ff) begin
               num_ff <= {prod[62:0], 1'b0};
               den_ff <= {1'b0, a_ff} + {1'b0, b_ff};
               rem_ff <= '0;
            end else begin
               mag_ff <= zero_ff ? 32'd0 : mag_simple;
            end
         end
         ST_DIV: begin
            rem_ff <= ge ? 33'(rem_sh - {1'b0, den_ff}) : rem_sh[32:0];
            num_ff <= {num_ff[62:0], ge};
            if (cnt_ff == 6'd63) begin
               mag_ff <= {num_ff[30:0], ge};
            end
         end
         ST_APPLY: begin
            lres_ff[k_ff] <= sat34($signed({{2{q_job.prev[k_ff][31]}}, q_job.prev[k_ff]})
                                   + $signed({h[32], h}));
            rres_ff[k_ff] <= sat34($signed({{2{q_job.cur[k_ff][31]}}, q_job.cur[k_ff]})
                                   - $signed({h[32], h}));
         end
         default: ;
      endcase
      if (pop) begin
         lout_ff <= lres_ff;
         rout_ff <= rres_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= 2'd0;
         cnt_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               k_ff <= 2'd0;
               if (q_valid) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: state_ff <= ST_MAG;
            ST_MAG: begin
               cnt_ff <= 6'd0;
               state_ff <= (mode == MODE_VANLEER && !zero_ff) ? ST_DIV : ST_APPLY;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               k_ff <= k_ff + 2'd1;
               state_ff <= (k_ff == 2'(NUM_COMP - 1)) ? ST_OUT : ST_LOAD;
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/limited_slope_reconstruction.sv =====
// top level of the slope-limited interface reconstruction: front, queue, back, limiter register
// depends on lsr_pkg, lsr_front, lsr_queue, lsr_back
//
//   channel | handshake            | payload
//   req     | req_valid/req_stall  | cell: density, two velocities, pressure, line_start
//   rsp     | rsp_valid/rsp_stall  | left and right interface states
//   csr     | csr_valid/csr_ready  | limiter_mode
//
// the front takes a cell per cycle while the two-entry queue has room
// the back handles one queued request at a time, taking each component through load, magnitude
// and apply steps, with bit-serial divider steps before apply for a nonzero van leer slope
// a ghost cell or the first two cells of a line give no response
// synchronous reset clears the history, queue, limiter (minmod) and response valid
// rsp_stall holds the output register; the back waits in its last step, then req stalls
module limited_slope_reconstruction
   import lsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_density,
   input  logic [31:0] req_velocity_a,
   input  logic [31:0] req_velocity_b,
   input  logic [31:0] req_pressure,
   input  logic        req_line_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_left_density,
   output logic [31:0] rsp_left_velocity_a,
   output logic [31:0] rsp_left_velocity_b,
   output logic [31:0] rsp_left_pressure,
   output logic [31:0] rsp_right_density,
   output logic [31:0] rsp_right_velocity_a,
   output logic [31:0] rsp_right_velocity_b,
   output logic [31:0] rsp_right_pressure,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_limiter_mode
);

   logic [1:0] limiter_ff;
   logic       q_full, push, q_valid, pop;
   job_type    push_job, q_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limiter_ff <= MODE_MINMOD;
      end else if (csr_valid && csr_ready) begin
         limiter_ff <= csr_limiter_mode;
      end
   end

   lsr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_density    (req_density),
      .req_velocity_a (req_velocity_a),
      .req_velocity_b (req_velocity_b),
      .req_pressure   (req_pressure),
      .req_line_start (req_line_start),
      .q_full         (q_full),
      .push           (push),
      .push_job       (push_job)
   );

   lsr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .q_valid  (q_valid),
      .q_job    (q_job),
      .pop      (pop)
   );

   lsr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .mode                 (limiter_ff),
      .q_valid              (q_valid),
      .q_job                (q_job),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_left_density     (rsp_left_density),
      .rsp_left_velocity_a  (rsp_left_velocity_a),
      .rsp_left_velocity_b  (rsp_left_velocity_b),
      .rsp_left_pressure    (rsp_left_pressure),
      .rsp_right_density    (rsp_right_density),
      .rsp_right_velocity_a (rsp_right_velocity_a),
      .rsp_right_velocity_b (rsp_right_velocity_b),
      .rsp_right_pressure   (rsp_right_pressure)
   );

endmodule

// ===== sim/limited_slope_reconstruction_test.sv =====
// testbench for limited_slope_reconstruction: directed and random cell streams
// checked against a slope-limiter predictor; depends on lsr_pkg and the rtl
`timescale 1ns / 100ps

module limited_slope_reconstruction_test;
   import lsr_pkg::*;

   localparam logic [1:0] MODE_FLAT = 2'd3;
   localparam int CYCLE_LIMIT = 10000000;

   typedef struct {
      logic [31:0] left [NUM_COMP];
      logic [31:0] right [NUM_COMP];
   } faces_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_density = '0;
   logic [31:0] req_velocity_a = '0;
   logic [31:0] req_velocity_b = '0;
   logic [31:0] req_pressure = '0;
   logic req_line_start = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_left_density, rsp_left_velocity_a, rsp_left_velocity_b;
   logic [31:0] rsp_left_pressure, rsp_right_density, rsp_right_velocity_a;
   logic [31:0] rsp_right_velocity_b, rsp_right_pressure;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_limiter_mode = '0;

   limited_slope_reconstruction i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] hist_one [NUM_COMP];
   logic signed [31:0] hist_two [NUM_COMP];
   int unsigned cells_held;
   logic [1:0] limiter;
   faces_type expected_faces [$];
   int errors = 0;
   int unsigned cycles = 0;
   int hold_off = 0;
   logic rsp_random = 1'b1;

   function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] limited_half(input logic signed [63:0] dm,
                                                       input logic signed [63:0] dp);
      logic [63:0] a, b, mag;
      logic neg;
      if (dm == 0 || dp == 0 || ((dm < 0) != (dp < 0))) return 0;
      neg = dm < 0;
      a = neg ? -dm : dm;
      b = neg ? -dp : dp;
      case (limiter)
         MODE_MINMOD: mag = (a < b) ? a : b;
         MODE_SUPERBEE: begin
            mag = ((2 * a < b) ? 2 * a : b);
            if (((a < 2 * b) ? a : 2 * b) > mag) mag = (a < 2 * b) ? a : 2 * b;
         end
         MODE_VANLEER: mag = (2 * a * b) / (a + b);
         default: mag = 0;
      endcase
      mag = mag >> 1;
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   task automatic predict_cell(input logic signed [31:0] cur_cell [NUM_COMP], input logic ls);
      faces_type f;
      logic signed [63:0] dm, dp, h;
      if (ls) begin
         for (int k = 0; k < NUM_COMP; k++) begin
            hist_two[k] = 0;
            hist_one[k] = cur_cell[k];
         end
         cells_held = 1;
         return;
      end
      if (cells_held >= 2) begin
         for (int k = 0; k < NUM_COMP; k++) begin
            dm = clamp(64'(hist_one[k]) - 64'(hist_two[k]));
            dp = clamp(64'(cur_cell[k]) - 64'(hist_one[k]));
            h = limited_half(dm, dp);
            f.left[k] = clamp(64'(hist_one[k]) + h);
            f.right[k] = clamp(64'(cur_cell[k]) - h);
         end
         expected_faces.push_back(f);
      end else begin
         cells_held++;
      end
      for (int k = 0; k < NUM_COMP; k++) begin
         hist_two[k] = hist_one[k];
         hist_one[k] = cur_cell[k];
      end
   endtask

   // idle gap before a request; valid drops only when the gap is not empty
   task automatic short_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // one request: held until accepted, valid stays up for the next one
   task automatic send_cell(input logic [31:0] d, va, vb, p, input logic ls, input bit gaps);
      logic signed [31:0] c [NUM_COMP];
      if (gaps) short_gap();
      req_valid <= 1'b1;
      req_density <= d;
      req_velocity_a <= va;
      req_velocity_b <= vb;
      req_pressure <= p;
      req_line_start <= ls;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      c[0] = d; c[1] = va; c[2] = vb; c[3] = p;
      predict_cell(c, ls);
   endtask

   task automatic write_limiter(input logic [1:0] mode);
      req_valid <= 1'b0;
      while (expected_faces.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_valid <= 1'b1;
      csr_limiter_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limiter = mode;
   endtask

   function automatic logic [31:0] any_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 4) << 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes();
      logic [31:0] v [6];
      v = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h7fff_ffff};
      foreach (v[i]) send_cell(v[i], ~v[i], v[i] ^ 32'h5555_5555, v[5 - i], 1'b0, 0);
   endtask

   task automatic test_smooth_lines(input int count);
      logic [31:0] base [NUM_COMP];
      logic [31:0] step [NUM_COMP];
      int len;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < NUM_COMP; k++) begin
            base[k] = any_value();
            step[k] = ($urandom_range(0, 3) == 0) ? any_value()
                    : $urandom_range(0, 'h3ffff) - 'h20000;
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         send_cell(base[0], base[1], base[2], base[3], 1'b1, 1);
         for (int c = 0; c < len; c++) begin
            for (int k = 0; k < NUM_COMP; k++)
               base[k] = ($urandom_range(0, 7) == 0) ? any_value()
                       : base[k] + step[k] + $urandom_range(0, 'hffff) - 'h8000;
            send_cell(base[0], base[1], base[2], base[3], $urandom_range(0, 30) == 0, 1);
         end
      end
   endtask

   task automatic test_backpressure();
      hold_off = 400;
      for (int i = 0; i < 20; i++)
         send_cell(any_value(), any_value(), any_value(), any_value(), i == 0, 0);
   endtask

   // receiver: random stalls plus a counted hold-off
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_random) begin
         rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      faces_type f;
      logic [31:0] got [8];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_left_density, rsp_left_velocity_a, rsp_left_velocity_b, rsp_left_pressure,
                 rsp_right_density, rsp_right_velocity_a, rsp_right_velocity_b,
                 rsp_right_pressure};
         if (expected_faces.size() == 0) begin
            $display("%0t: unexpected response", $time);
            errors++;
         end else begin
            f = expected_faces.pop_front();
            for (int k = 0; k < NUM_COMP; k++) begin
               if (got[k] !== f.left[k]) begin
                  $display("%0t: left[%0d] expected %h got %h", $time, k, f.left[k], got[k]);
                  errors++;
               end
               if (got[NUM_COMP + k] !== f.right[k]) begin
                  $display("%0t: right[%0d] expected %h got %h", $time, k, f.right[k],
                           got[NUM_COMP + k]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < NUM_COMP; k++) begin
         hist_one[k] = 0;
         hist_two[k] = 0;
      end
      cells_held = 0;
      limiter = MODE_MINMOD;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // cells before any line start count as a line
      test_extremes();
      write_limiter(MODE_SUPERBEE);
      test_extremes();
      write_limiter(MODE_VANLEER);
      test_extremes();
      write_limiter(MODE_FLAT);
      test_smooth_lines(3);
      write_limiter(MODE_MINMOD);
      test_backpressure();
      test_smooth_lines(60);
      write_limiter(MODE_SUPERBEE);
      test_smooth_lines(60);
      write_limiter(MODE_VANLEER);
      test_smooth_lines(60);
      rsp_random = 1'b0;
      write_limiter(MODE_FLAT);
      test_smooth_lines(10);
      rsp_random = 1'b1;
      write_limiter(MODE_VANLEER);
      test_smooth_lines(40);
      req_valid <= 1'b0;
      while (expected_faces.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
